// ===== sv/gns_pkg.sv =====
// shared types, codes and constants of the grid neighbor search block
// no dependencies
package gns_pkg;

   localparam int MAX_POINTS_DEF = 64;
   localparam int MAX_RESULTS    = 64;
   localparam int CS_W           = 23;
   localparam logic [CS_W-1:0] CS_RESET = 23'd256;

   typedef enum logic [1:0] {
      CMD_CLEAR,
      CMD_INSERT,
      CMD_NEIGHBOR,
      CMD_AGGREGATE
   } command_type;

   typedef enum logic [1:0] {
      KIND_EMPTY,
      KIND_NEIGHBOR,
      KIND_AGGREGATE
   } kind_type;

   typedef struct packed {
      command_type        command;
      logic [15:0]        item_index;
      logic signed [23:0] pos_x;
      logic signed [23:0] pos_y;
      logic signed [23:0] pos_z;
      logic signed [23:0] vel_x;
      logic signed [23:0] vel_y;
      logic signed [23:0] vel_z;
      logic signed [23:0] radius;
   } req_type;

   typedef struct packed {
      kind_type           kind;
      logic [15:0]        index_or_count;
      logic signed [23:0] cell_x;
      logic signed [23:0] cell_y;
      logic signed [23:0] cell_z;
      logic signed [23:0] centroid_x;
      logic signed [23:0] centroid_y;
      logic signed [23:0] centroid_z;
      logic signed [23:0] mean_vel_x;
      logic signed [23:0] mean_vel_y;
      logic signed [23:0] mean_vel_z;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic signed [23:0] cz;
      logic signed [23:0] cy;
      logic signed [23:0] cx;
      logic [15:0]        id;
      logic signed [23:0] px;
      logic signed [23:0] py;
      logic signed [23:0] pz;
      logic signed [23:0] vx;
      logic signed [23:0] vy;
      logic signed [23:0] vz;
   } entry_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_DECODE,
      S_CELL_GO,
      S_CELL_WAIT,
      S_INS_RD,
      S_INS_CMP,
      S_SH_RD,
      S_SH_WR,
      S_INS_WR,
      S_CR_GO,
      S_CR_WAIT,
      S_R2_MUL,
      S_R2_ST,
      S_Q_RD,
      S_Q_CHK,
      S_AG_RD,
      S_AG_CHK,
      S_AG_END,
      S_MEAN_GO,
      S_MEAN_WAIT,
      S_M0,
      S_M1,
      S_M2,
      S_M3,
      S_TEST,
      S_FINISH
   } state_type;

   typedef enum logic {RD_CUR, RD_PREV} rd_sel_type;
   typedef enum logic {WR_SHIFT, WR_NEW} wr_sel_type;
   typedef enum logic [2:0] {I_HOLD, I_ZERO, I_INC, I_DEC, I_COUNT} i_op_type;
   typedef enum logic [1:0] {DIV_CELL, DIV_CR, DIV_MEAN} div_sel_type;
   typedef enum logic [1:0] {MUL_R, MUL_DX, MUL_DY, MUL_DZ} mul_sel_type;
   typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD} acc_op_type;

   typedef struct packed {
      logic        rd_en;
      rd_sel_type  rd_sel;
      logic        wr_en;
      wr_sel_type  wr_sel;
      i_op_type    i_op;
      logic        set_pos;
      logic        count_clear;
      logic        count_inc;
      logic        div_start;
      div_sel_type div_sel;
      logic        store_c;
      logic        store_cr;
      logic        store_mean;
      mul_sel_type mul_sel;
      logic        store_r2;
      acc_op_type  acc_op;
      logic        test;
      logic        grp_load;
      logic        grp_add;
      logic        q_init;
      logic        finish;
      logic [2:0]  ax;
   } ctrl_cmd_type;

   typedef struct packed {
      command_type op;
      logic        i_eq_count;
      logic        i_eq_pos;
      logic        full;
      logic        key_gt;
      logic        in_cube;
      logic        same_cell;
      logic        k_full;
      logic        div_done;
      logic        neg_radius;
   } dp_stat_type;

endpackage

// ===== sv/grid_neighbor_search.sv =====
// uniform grid neighbor search top level: sorted point table with neighbor and cell queries
// depends on gns_pkg, gns_ctrl and gns_dp. an insert or query does 3 cell divisions, one per
// axis; an insert then scans the stored points and shifts those after its place, a query
// does one ceiling division, a scan of the points and, when it aggregates, 6 divisions per cell
// in range. one item at a time: busy stays high until the last result of a query; the
// receiver cannot stall. reset empties the table and sets the cell edge to 256.
module grid_neighbor_search
   import gns_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  req_type         req_item,
   input  logic            csr_we,
   input  logic [CS_W-1:0] csr_wdata,
   output logic            rsp_valid,
   output rsp_type         rsp_item
);

   ctrl_cmd_type cmd;
   dp_stat_type  stat;
   logic         start_accept;

   assign start_accept = start && !busy;

   gns_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .start_accept (start_accept),
      .stat         (stat),
      .cmd          (cmd),
      .busy         (busy)
   );

   gns_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
      .clock        (clock),
      .reset        (reset),
      .start_accept (start_accept),
      .req_item     (req_item),
      .csr_we       (csr_we),
      .csr_wdata    (csr_wdata),
      .cmd          (cmd),
      .stat         (stat),
      .rsp_valid    (rsp_valid),
      .rsp_item     (rsp_item)
   );

endmodule

// ===== sv/gns_div.sv =====
// restoring divider, one quotient bit per cycle, unsigned operands
// depends on gns_pkg
module gns_div
   import gns_pkg::*;
#(
   parameter int NW = 31
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [NW-1:0]   dividend,
   input  logic [CS_W-1:0] divisor,
   output logic            done,
   output logic [NW-1:0]   quot,
   output logic            rem_nz
);

   localparam int KW = $clog2(NW + 1);

   logic [NW-1:0]   q_ff, q_in;
   logic [CS_W-1:0] r_ff, r_in;
   logic [KW-1:0]   cnt_ff, cnt_in;
   logic            run_ff, run_in;
   logic            done_ff, done_in;
   logic [CS_W:0]   shifted;
   logic [CS_W+1:0] trial;

   always_comb begin
      shifted = {r_ff, q_ff[NW-1]};
      trial   = {1'b0, shifted} - {2'b00, divisor};
      q_in    = q_ff;
      r_in    = r_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         q_in   = dividend;
         r_in   = '0;
         cnt_in = KW'(NW);
         run_in = 1'b1;
      end else if (run_ff) begin
         if (!trial[CS_W+1]) begin
            r_in = trial[CS_W-1:0];
            q_in = {q_ff[NW-2:0], 1'b1};
         end else begin
            r_in = shifted[CS_W-1:0];
            q_in = {q_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == KW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      r_ff <= r_in;
      if (reset) begin
         cnt_ff  <= '0;
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign done   = done_ff;
   assign quot   = q_ff;
   assign rem_nz = |r_ff;

endmodule

// ===== sv/gns_ctrl.sv =====
// sequencing state machine: cell divisions, sorted insert, table scans
// depends on gns_pkg
module gns_ctrl
   import gns_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start_accept,
   input  dp_stat_type  stat,
   output ctrl_cmd_type cmd,
   output logic         busy
);

   state_type  state_ff, state_in;
   logic [2:0] ax_ff, ax_in;

   always_comb begin
      state_in = state_ff;
      ax_in    = ax_ff;
      unique case (state_ff)
         S_IDLE: if (start_accept) state_in = S_DECODE;
         S_DECODE: begin
            ax_in = '0;
            state_in = (stat.op == CMD_CLEAR) ? S_IDLE : S_CELL_GO;
         end
         S_CELL_GO: state_in = S_CELL_WAIT;
         S_CELL_WAIT: begin
            if (stat.div_done) begin
               if (ax_ff == 3'd2) begin
                  ax_in = '0;
                  if (stat.op == CMD_INSERT) begin
                     state_in = stat.full ? S_IDLE : S_INS_RD;
                  end else begin
                     state_in = stat.neg_radius ? S_FINISH : S_CR_GO;
                  end
               end else begin
                  ax_in = ax_ff + 3'd1;
                  state_in = S_CELL_GO;
               end
            end
         end
         S_INS_RD:  state_in = stat.i_eq_count ? S_INS_WR : S_INS_CMP;
         S_INS_CMP: state_in = stat.key_gt ? S_SH_RD : S_INS_RD;
         S_SH_RD:   state_in = stat.i_eq_pos ? S_INS_WR : S_SH_WR;
         S_SH_WR:   state_in = S_SH_RD;
         S_INS_WR:  state_in = S_IDLE;
         S_CR_GO:   state_in = S_CR_WAIT;
         S_CR_WAIT: if (stat.div_done) state_in = S_R2_MUL;
         S_R2_MUL:  state_in = S_R2_ST;
         S_R2_ST:   state_in = S_Q_RD;
         S_Q_RD:    state_in = (stat.i_eq_count || stat.k_full) ? S_FINISH : S_Q_CHK;
         S_Q_CHK: begin
            if (stat.op == CMD_AGGREGATE) begin
               state_in = S_AG_RD;
            end else begin
               state_in = stat.in_cube ? S_M0 : S_Q_RD;
            end
         end
         S_AG_RD:  state_in = stat.i_eq_count ? S_AG_END : S_AG_CHK;
         S_AG_CHK: state_in = stat.same_cell ? S_AG_RD : S_AG_END;
         S_AG_END: begin
            ax_in = '0;
            state_in = stat.in_cube ? S_MEAN_GO : S_Q_RD;
         end
         S_MEAN_GO: state_in = S_MEAN_WAIT;
         S_MEAN_WAIT: begin
            if (stat.div_done) begin
               if (ax_ff == 3'd5) begin
                  ax_in = '0;
                  state_in = S_M0;
               end else begin
                  ax_in = ax_ff + 3'd1;
                  state_in = S_MEAN_GO;
               end
            end
         end
         S_M0:     state_in = S_M1;
         S_M1:     state_in = S_M2;
         S_M2:     state_in = S_M3;
         S_M3:     state_in = S_TEST;
         S_TEST:   state_in = S_Q_RD;
         S_FINISH: state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd    = '0;
      cmd.ax = ax_ff;
      unique case (state_ff)
         S_DECODE: cmd.count_clear = (stat.op == CMD_CLEAR);
         S_CELL_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_CELL;
         end
         S_CELL_WAIT: begin
            cmd.div_sel = DIV_CELL;
            if (stat.div_done) begin
               cmd.store_c = 1'b1;
               if (ax_ff == 3'd2) begin
                  cmd.i_op   = I_ZERO;
                  cmd.q_init = (stat.op != CMD_INSERT);
               end
            end
         end
         S_INS_RD: begin
            if (stat.i_eq_count) begin
               cmd.set_pos = 1'b1;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_CUR;
            end
         end
         S_INS_CMP: begin
            if (stat.key_gt) begin
               cmd.set_pos = 1'b1;
               cmd.i_op    = I_COUNT;
            end else begin
               cmd.i_op = I_INC;
            end
         end
         S_SH_RD: begin
            if (!stat.i_eq_pos) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_PREV;
            end
         end
         S_SH_WR: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WR_SHIFT;
            cmd.i_op   = I_DEC;
         end
         S_INS_WR: begin
            cmd.wr_en     = 1'b1;
            cmd.wr_sel    = WR_NEW;
            cmd.count_inc = 1'b1;
         end
         S_CR_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_CR;
         end
         S_CR_WAIT: begin
            cmd.div_sel  = DIV_CR;
            cmd.store_cr = stat.div_done;
         end
         S_R2_MUL: cmd.mul_sel = MUL_R;
         S_R2_ST:  cmd.store_r2 = 1'b1;
         S_Q_RD: begin
            if (!(stat.i_eq_count || stat.k_full)) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_CUR;
            end
         end
         S_Q_CHK: begin
            cmd.i_op     = I_INC;
            cmd.grp_load = (stat.op == CMD_AGGREGATE);
         end
         S_AG_RD: begin
            if (!stat.i_eq_count) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_CUR;
            end
         end
         S_AG_CHK: begin
            if (stat.same_cell) begin
               cmd.grp_add = 1'b1;
               cmd.i_op    = I_INC;
            end
         end
         S_MEAN_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_MEAN;
         end
         S_MEAN_WAIT: begin
            cmd.div_sel    = DIV_MEAN;
            cmd.store_mean = stat.div_done;
         end
         S_M0: cmd.mul_sel = MUL_DX;
         S_M1: begin
            cmd.mul_sel = MUL_DY;
            cmd.acc_op  = ACC_LOAD;
         end
         S_M2: begin
            cmd.mul_sel = MUL_DZ;
            cmd.acc_op  = ACC_ADD;
         end
         S_M3:     cmd.acc_op = ACC_ADD;
         S_TEST:   cmd.test = 1'b1;
         S_FINISH: cmd.finish = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ax_ff    <= '0;
      end else begin
         state_ff <= state_in;
         ax_ff    <= ax_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   a_ax_range: assert property (@(posedge clock) disable iff (reset)
      ax_ff <= 3'd5) else $error("axis counter out of range");
   a_done_waits: assert property (@(posedge clock) disable iff (reset)
      (stat.div_done && state_ff != S_IDLE) |->
         (state_ff == S_CELL_WAIT || state_ff == S_CR_WAIT || state_ff == S_MEAN_WAIT))
      else $error("divider finished outside a wait state");
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      start_accept |=> state_ff == S_DECODE) else $error("item not decoded");

endmodule

// ===== sv/gns_dp.sv =====
// datapath: point table memory, divider, squaring multiplier, result registers
// depends on gns_pkg and gns_div
module gns_dp
   import gns_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start_accept,
   input  req_type         req_item,
   input  logic            csr_we,
   input  logic [CS_W-1:0] csr_wdata,
   input  ctrl_cmd_type    cmd,
   output dp_stat_type     stat,
   output logic            rsp_valid,
   output rsp_type         rsp_item
);

   localparam int AW = $clog2(MAX_POINTS);
   localparam int CW = $clog2(MAX_POINTS + 1);
   localparam int SW = 24 + CW;
   localparam int KW = $clog2(MAX_RESULTS + 1);

   entry_type mem [MAX_POINTS];
   entry_type rd_ff;

   req_type            req_ff;
   logic [CS_W-1:0]    cs_ff, cs_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      i_ff, i_in;
   logic [CW-1:0]      pos_ff, pos_in;
   logic signed [23:0] c_ff [3];
   logic signed [23:0] c_in [3];
   logic [24:0]        cr_ff, cr_in;
   logic [47:0]        r2_ff, r2_in;
   logic signed [49:0] prod_ff;
   logic [51:0]        acc_ff, acc_in;
   entry_type          head_ff, head_in;
   logic signed [SW-1:0] sp_ff [3];
   logic signed [SW-1:0] sp_in [3];
   logic signed [SW-1:0] sv_ff [3];
   logic signed [SW-1:0] sv_in [3];
   logic [CW-1:0]      n_ff, n_in;
   logic signed [23:0] mean_ff [6];
   logic signed [23:0] mean_in [6];
   rsp_type            pend_ff, pend_in;
   logic               pend_v_ff, pend_v_in;
   logic [KW-1:0]      k_ff, k_in;
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_v_ff, rsp_v_in;

   logic [CS_W-1:0]    cs_eff;
   logic signed [23:0] p_arr [3];
   logic signed [23:0] rd_pos [3];
   logic signed [23:0] rd_vel [3];
   logic signed [SW-1:0] div_val;
   logic [SW-1:0]      div_a;
   logic [CS_W-1:0]    div_b;
   logic               div_neg;
   logic               div_done;
   logic [SW-1:0]      quot;
   logic               rem_nz;
   logic signed [SW-1:0] q_signed;
   logic [1:0]         mx;
   logic signed [23:0] m_src;
   logic signed [24:0] mul_a;
   logic               agg;
   entry_type          cube_src;
   logic [2:0]         cube_ok;
   logic signed [24:0] cdiff [3];
   logic [24:0]        cabs [3];
   logic [AW-1:0]      rd_addr;
   logic [AW-1:0]      wr_addr;
   entry_type          wr_data;
   entry_type          new_entry;
   logic [CW-1:0]      i_prev;
   logic               hit;
   rsp_type            hit_rsp;

   assign cs_eff = (cs_ff == '0) ? CS_W'(1) : cs_ff;
   assign agg    = (req_ff.command == CMD_AGGREGATE);

   assign p_arr[0]  = req_ff.pos_x;
   assign p_arr[1]  = req_ff.pos_y;
   assign p_arr[2]  = req_ff.pos_z;
   assign rd_pos[0] = rd_ff.px;
   assign rd_pos[1] = rd_ff.py;
   assign rd_pos[2] = rd_ff.pz;
   assign rd_vel[0] = rd_ff.vx;
   assign rd_vel[1] = rd_ff.vy;
   assign rd_vel[2] = rd_ff.vz;

   // divider operand select, magnitude in and sign fixed after
   always_comb begin
      div_val = '0;
      div_b   = cs_eff;
      case (cmd.div_sel)
         DIV_CELL: div_val = SW'(p_arr[cmd.ax[1:0]]);
         DIV_CR:   div_val = SW'(req_ff.radius) + SW'(cs_eff) - SW'(1);
         DIV_MEAN: begin
            div_b = CS_W'(n_ff);
            if (cmd.ax < 3'd3) begin
               div_val = sp_ff[cmd.ax[1:0]];
            end else begin
               div_val = sv_ff[2'(cmd.ax - 3'd3)];
            end
         end
         default: div_val = '0;
      endcase
      div_neg = div_val[SW-1];
      div_a   = div_neg ? SW'(-div_val) : SW'(div_val);
   end

   gns_div #(.NW(SW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_a),
      .divisor  (div_b),
      .done     (div_done),
      .quot     (quot),
      .rem_nz   (rem_nz)
   );

   assign q_signed = div_neg ? -$signed(quot) : $signed(quot);

   // squared difference or radius operand
   always_comb begin
      mx = 2'd0;
      case (cmd.mul_sel)
         MUL_DX:  mx = 2'd0;
         MUL_DY:  mx = 2'd1;
         MUL_DZ:  mx = 2'd2;
         default: mx = 2'd0;
      endcase
      m_src = agg ? mean_ff[{1'b0, mx}] : rd_pos[mx];
      if (cmd.mul_sel == MUL_R) begin
         mul_a = 25'(req_ff.radius);
      end else begin
         mul_a = 25'(m_src) - 25'(p_arr[mx]);
      end
   end

   // cube test against the query cell
   always_comb begin
      cube_src = agg ? head_ff : rd_ff;
      cdiff[0] = 25'(cube_src.cx) - 25'(c_ff[0]);
      cdiff[1] = 25'(cube_src.cy) - 25'(c_ff[1]);
      cdiff[2] = 25'(cube_src.cz) - 25'(c_ff[2]);
      for (int a = 0; a < 3; a++) begin
         cabs[a]    = cdiff[a][24] ? 25'(-cdiff[a]) : 25'(cdiff[a]);
         cube_ok[a] = (cabs[a] <= cr_ff);
      end
   end

   always_comb begin
      new_entry    = '0;
      new_entry.cx = c_ff[0];
      new_entry.cy = c_ff[1];
      new_entry.cz = c_ff[2];
      new_entry.id = req_ff.item_index;
      new_entry.px = req_ff.pos_x;
      new_entry.py = req_ff.pos_y;
      new_entry.pz = req_ff.pos_z;
      new_entry.vx = req_ff.vel_x;
      new_entry.vy = req_ff.vel_y;
      new_entry.vz = req_ff.vel_z;
      i_prev  = i_ff - CW'(1);
      rd_addr = (cmd.rd_sel == RD_PREV) ? i_prev[AW-1:0] : i_ff[AW-1:0];
      wr_addr = (cmd.wr_sel == WR_NEW) ? pos_ff[AW-1:0] : i_ff[AW-1:0];
      wr_data = (cmd.wr_sel == WR_NEW) ? new_entry : rd_ff;
   end

   always_comb begin
      hit_rsp = '0;
      if (agg) begin
         hit_rsp.kind           = KIND_AGGREGATE;
         hit_rsp.index_or_count = 16'(n_ff);
         hit_rsp.cell_x         = head_ff.cx;
         hit_rsp.cell_y         = head_ff.cy;
         hit_rsp.cell_z         = head_ff.cz;
         hit_rsp.centroid_x     = mean_ff[0];
         hit_rsp.centroid_y     = mean_ff[1];
         hit_rsp.centroid_z     = mean_ff[2];
         hit_rsp.mean_vel_x     = mean_ff[3];
         hit_rsp.mean_vel_y     = mean_ff[4];
         hit_rsp.mean_vel_z     = mean_ff[5];
      end else begin
         hit_rsp.kind           = KIND_NEIGHBOR;
         hit_rsp.index_or_count = rd_ff.id;
      end
      hit = cmd.test && (acc_ff <= 52'(r2_ff));
   end

   always_comb begin
      cs_in     = csr_we ? csr_wdata : cs_ff;
      count_in  = count_ff;
      i_in      = i_ff;
      pos_in    = cmd.set_pos ? i_ff : pos_ff;
      c_in      = c_ff;
      cr_in     = cmd.store_cr ? 25'(quot) : cr_ff;
      r2_in     = cmd.store_r2 ? 48'(prod_ff) : r2_ff;
      acc_in    = acc_ff;
      head_in   = head_ff;
      sp_in     = sp_ff;
      sv_in     = sv_ff;
      n_in      = n_ff;
      mean_in   = mean_ff;
      pend_in   = pend_ff;
      pend_v_in = pend_v_ff;
      k_in      = k_ff;
      rsp_in    = rsp_ff;
      rsp_v_in  = 1'b0;

      if (cmd.count_clear) count_in = '0;
      if (cmd.count_inc)   count_in = count_ff + CW'(1);

      case (cmd.i_op)
         I_ZERO:  i_in = '0;
         I_INC:   i_in = i_ff + CW'(1);
         I_DEC:   i_in = i_prev;
         I_COUNT: i_in = count_ff;
         default: i_in = i_ff;
      endcase

      // floor division: round toward minus infinity on a remainder
      if (cmd.store_c) begin
         c_in[cmd.ax[1:0]] = 24'(q_signed - SW'(div_neg && rem_nz));
      end
      if (cmd.store_mean) mean_in[cmd.ax] = 24'(q_signed);

      case (cmd.acc_op)
         ACC_LOAD: acc_in = 52'($unsigned(prod_ff));
         ACC_ADD:  acc_in = acc_ff + 52'($unsigned(prod_ff));
         default:  acc_in = acc_ff;
      endcase

      if (cmd.grp_load) begin
         head_in = rd_ff;
         n_in    = CW'(1);
         for (int a = 0; a < 3; a++) begin
            sp_in[a] = SW'(rd_pos[a]);
            sv_in[a] = SW'(rd_vel[a]);
         end
      end else if (cmd.grp_add) begin
         n_in = n_ff + CW'(1);
         for (int a = 0; a < 3; a++) begin
            sp_in[a] = sp_ff[a] + SW'(rd_pos[a]);
            sv_in[a] = sv_ff[a] + SW'(rd_vel[a]);
         end
      end

      if (cmd.q_init) begin
         k_in      = '0;
         pend_v_in = 1'b0;
      end

      // one hit held back so that the final item can carry last
      if (hit) begin
         if (pend_v_ff) begin
            rsp_in   = pend_ff;
            rsp_v_in = 1'b1;
         end
         pend_in   = hit_rsp;
         pend_v_in = 1'b1;
         k_in      = k_ff + KW'(1);
      end

      if (cmd.finish) begin
         rsp_in      = pend_v_ff ? pend_ff : '0;
         rsp_in.last = 1'b1;
         rsp_v_in    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) rd_ff <= mem[rd_addr];
      if (cmd.wr_en) mem[wr_addr] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (start_accept) req_ff <= req_item;
      pos_ff  <= pos_in;
      c_ff    <= c_in;
      cr_ff   <= cr_in;
      r2_ff   <= r2_in;
      prod_ff <= mul_a * mul_a;
      acc_ff  <= acc_in;
      head_ff <= head_in;
      sp_ff   <= sp_in;
      sv_ff   <= sv_in;
      n_ff    <= n_in;
      mean_ff <= mean_in;
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
      if (reset) begin
         cs_ff     <= CS_RESET;
         count_ff  <= '0;
         i_ff      <= '0;
         pend_v_ff <= 1'b0;
         k_ff      <= '0;
         rsp_v_ff  <= 1'b0;
      end else begin
         cs_ff     <= cs_in;
         count_ff  <= count_in;
         i_ff      <= i_in;
         pend_v_ff <= pend_v_in;
         k_ff      <= k_in;
         rsp_v_ff  <= rsp_v_in;
      end
   end

   always_comb begin
      stat            = '0;
      stat.op         = req_ff.command;
      stat.i_eq_count = (i_ff == count_ff);
      stat.i_eq_pos   = (i_ff == pos_ff);
      stat.full       = (count_ff == CW'(MAX_POINTS));
      if (rd_ff.cz != c_ff[2]) begin
         stat.key_gt = (rd_ff.cz > c_ff[2]);
      end else if (rd_ff.cy != c_ff[1]) begin
         stat.key_gt = (rd_ff.cy > c_ff[1]);
      end else if (rd_ff.cx != c_ff[0]) begin
         stat.key_gt = (rd_ff.cx > c_ff[0]);
      end else begin
         stat.key_gt = (rd_ff.id > req_ff.item_index);
      end
      stat.in_cube    = &cube_ok;
      stat.same_cell  = (rd_ff.cx == head_ff.cx) && (rd_ff.cy == head_ff.cy) &&
                        (rd_ff.cz == head_ff.cz);
      stat.k_full     = (k_ff == KW'(MAX_RESULTS));
      stat.div_done   = div_done;
      stat.neg_radius = req_ff.radius[23];
   end

   assign rsp_valid = rsp_v_ff;
   assign rsp_item  = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_POINTS)) else $error("table count above capacity");
   a_k_bound: assert property (@(posedge clock) disable iff (reset)
      k_ff <= KW'(MAX_RESULTS)) else $error("too many hits counted");
   a_rsp_query: assert property (@(posedge clock) disable iff (reset)
      rsp_v_ff |-> (req_ff.command == CMD_NEIGHBOR || req_ff.command == CMD_AGGREGATE))
      else $error("result item outside a query");
   a_no_write_full: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_en |-> count_ff < CW'(MAX_POINTS)) else $error("table write while full");

endmodule
